// File: rtl/eqola_pkg.sv
package eqola_pkg;

  // Transform size and fixed-point formats.
  localparam int LOG2N    = 10;
  localparam int N        = 1 << LOG2N;
  localparam int HOP      = N / 2;
  localparam int HA       = LOG2N - 1;
  localparam int W        = 24;
  localparam int F        = W - 8;
  localparam int SUM_W    = W + 6;
  localparam int MY_W     = 18;
  localparam int PROD_W   = W + MY_W;
  localparam int TW_W     = 17;
  localparam int WIN_W    = 15;
  localparam int SAMP_W   = 16;
  localparam int BIN_W    = 9;
  localparam int GAIN_W   = 16;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = LOG2N + 1;
  localparam int STG_W    = 4;
  localparam int IN_W     = 48;
  localparam int GAIN_ONE = 4096;

  // Request kinds on the input channel.
  localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAIN  = 2'd2;

  typedef logic signed [W-1:0]     work_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [TW_W-1:0]  tw_t;
  typedef tw_t                     tw_rom_t [HOP];
  typedef logic [WIN_W-1:0]        win_rom_t [N];

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_LD_RD, S_LD_MUL, S_LD_WR,
    S_BF_RD, S_BF_MUL, S_BF_WA, S_BF_WB,
    S_GN_RD, S_GN_MUL, S_GN_WA, S_GN_WB,
    S_SW_RD, S_SW_WJ, S_SW_WR,
    S_OV_RD, S_OV_WR,
    S_PD_RD, S_EMIT
  } state_t;

  localparam longint ONE_Q30 = 64'd1073741824;
  localparam longint SC_A1   = 64'd1686629713;
  localparam longint SC_A3   = 64'd693598668;
  localparam longint SC_A5   = 64'd85569306;
  localparam longint SC_A7   = 64'd5026995;
  localparam longint SC_A9   = 64'd172272;

  // Odd polynomial for sin(pi/2 * x), x and result in Q30.
  function automatic longint sin_quarter(input longint x);
    longint x2, t, r;
    x2 = (x * x) >>> 30;
    t  = SC_A7 - ((x2 * SC_A9) >>> 30);
    t  = SC_A5 - ((x2 * t) >>> 30);
    t  = SC_A3 - ((x2 * t) >>> 30);
    t  = SC_A1 - ((x2 * t) >>> 30);
    r  = (x * t) >>> 30;
    return (r > ONE_Q30) ? ONE_Q30 : r;
  endfunction

  // Cosine of a full-turn phase, 2^32 being one turn.
  function automatic longint trig_cos(input longint ph);
    longint q, r;
    q = (ph >>> 30) & 3;
    r = ph & 64'h3FFFFFFF;
    case (q)
      0:       return sin_quarter(ONE_Q30 - r);
      1:       return -sin_quarter(r);
      2:       return -sin_quarter(ONE_Q30 - r);
      default: return sin_quarter(r);
    endcase
  endfunction

  function automatic longint trig_sin(input longint ph);
    longint q, r;
    q = (ph >>> 30) & 3;
    r = ph & 64'h3FFFFFFF;
    case (q)
      0:       return sin_quarter(r);
      1:       return sin_quarter(ONE_Q30 - r);
      2:       return -sin_quarter(r);
      default: return -sin_quarter(ONE_Q30 - r);
    endcase
  endfunction

  // Symmetric Hann window in Q0.15.
  function automatic win_rom_t make_win_rom();
    win_rom_t rom;
    longint   ph, w;
    for (int j = 0; j < N; j++) begin
      ph = ((longint'(j) <<< 32) / (N - 1)) & 64'hFFFFFFFF;
      w  = ((ONE_Q30 - trig_cos(ph)) + 32768) >>> 16;
      rom[j] = WIN_W'((w > 32767) ? 32767 : w);
    end
    return rom;
  endfunction

  function automatic tw_rom_t make_tw_cos();
    tw_rom_t rom;
    longint  ph;
    for (int j = 0; j < HOP; j++) begin
      ph = ((longint'(j) <<< 32) / N) & 64'hFFFFFFFF;
      rom[j] = TW_W'((trig_cos(ph) + 16384) >>> 15);
    end
    return rom;
  endfunction

  function automatic tw_rom_t make_tw_sin();
    tw_rom_t rom;
    longint  ph;
    for (int j = 0; j < HOP; j++) begin
      ph = ((longint'(j) <<< 32) / N) & 64'hFFFFFFFF;
      rom[j] = TW_W'((trig_sin(ph) + 16384) >>> 15);
    end
    return rom;
  endfunction

  function automatic logic [LOG2N-1:0] bit_rev(input logic [LOG2N-1:0] v);
    logic [LOG2N-1:0] r;
    for (int k = 0; k < LOG2N; k++) begin
      r[k] = v[LOG2N-1-k];
    end
    return r;
  endfunction

  // Saturate a widened value to the work width.
  function automatic work_t sat_w(input sum_t v);
    sum_t hi, lo;
    hi = sum_t'((longint'(1) <<< (W - 1)) - 1);
    lo = -hi - sum_t'(1);
    if (v > hi) begin
      return work_t'(hi);
    end else if (v < lo) begin
      return work_t'(lo);
    end
    return work_t'(v);
  endfunction

endpackage

// File: rtl/fft_overlap_add_equalizer_unit.sv
// Streaming frequency-domain equalizer with 50% overlap-add.
// Input channel (in_*): one request per item. in_tuser is the kind: audio sample,
// end-of-stream zero pad, or gain table write. Output channel (out_*): equalized
// samples, with in_tuser-style flag out_tuser set when the sum was clamped.
// Item m of a stream gives output m-(N-1); earlier items give none. After the last
// real sample the host sends N-1 pads, after which the next stream starts fresh;
// the overlap tail is kept across streams.
// Processing: every N/2-th item runs a frame: window load, forward and inverse FFT
// on one shared radix-2 butterfly unit (2 * N/2 * log2 N butterflies), gain pass,
// bit-reverse pass and overlap pass. The single write port of the work memory
// sets the butterfly rate. in_tready is low while an item is in work.
// Reset: a clearing pass over the N/2 bins sets every gain to unity and the
// overlap store to zero; in_tready stays low meanwhile. A stalled receiver holds
// the result in the output register; the block still takes the next request and
// waits only when that one must emit as well.
module fft_overlap_add_equalizer_unit
  import eqola_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // sample_in[15:0], bin_index[24:16], bin_gain[40:25]
  input  logic [KIND_W-1:0] in_tuser,   // kind[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SAMP_W-1:0] out_tdata,  // sample_out[15:0]
  output logic [0:0]        out_tuser   // clipped[0]
);

  localparam win_rom_t WIN_ROM = make_win_rom();
  localparam tw_rom_t  TW_COS  = make_tw_cos();
  localparam tw_rom_t  TW_SIN  = make_tw_sin();

  // Memories.
  logic [SAMP_W-1:0]  hist_mem [N];
  logic [2*W-1:0]     work_mem [N];
  logic [GAIN_W-1:0]  gain_mem [HOP];
  logic [W-1:0]       ov_mem   [HOP];
  logic [SAMP_W:0]    pend_mem [HOP];

  // Control registers.
  state_t            state_r, state_nxt;
  logic [LOG2N-1:0]  idx_r, idx_nxt;
  logic [STG_W-1:0]  stage_r, stage_nxt;
  logic              inv_r, inv_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LOG2N-1:0]  pad_r, pad_nxt;
  logic [HA-1:0]     d_r, d_nxt;
  logic [LOG2N-1:0]  start_r, start_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [SAMP_W-1:0]        hist_q_r;
  logic [WIN_W-1:0]         win_q_r;
  tw_t                      twc_q_r, tws_q_r;
  logic [2*W-1:0]           rd_a_r, rd_b_r;
  logic [GAIN_W-1:0]        gain_q_r;
  logic [W-1:0]             ov_q_r;
  logic [SAMP_W:0]          pend_q_r;
  logic signed [PROD_W-1:0] prod_r [4];
  work_t                    v_re_r, v_im_r;
  logic [SAMP_W-1:0]        out_data_r;
  logic                     out_clip_r;

  // Memory port controls.
  logic              hist_we, work_we, gain_we, ov_we, pend_we, load_out, v_load;
  logic [LOG2N-1:0]  work_waddr, ra_addr, rb_addr;
  logic [2*W-1:0]    work_wdata;
  logic [HA-1:0]     gain_waddr, tw_addr;
  logic [GAIN_W-1:0] gain_wdata;
  work_t             ov_wdata;
  logic [SAMP_W:0]   pend_wdata;
  work_t             v_re_nxt, v_im_nxt;

  // Request fields.
  logic [KIND_W-1:0] kind;
  logic [SAMP_W-1:0] smp_in;
  logic [BIN_W-1:0]  bin_idx;
  logic [GAIN_W-1:0] bin_gain;

  assign kind     = in_tuser;
  assign smp_in   = in_tdata[15:0];
  assign bin_idx  = in_tdata[24:16];
  assign bin_gain = in_tdata[40:25];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // Unpacked work operands.
  work_t re_a, im_a, re_b, im_b;
  assign re_a = work_t'(rd_a_r[W-1:0]);
  assign im_a = work_t'(rd_a_r[2*W-1:W]);
  assign re_b = work_t'(rd_b_r[W-1:0]);
  assign im_b = work_t'(rd_b_r[2*W-1:W]);

  // Butterfly addressing for the current stage.
  logic [LOG2N-1:0] half, kk, bf_a, bf_b, ti_full, idx_rev;
  logic [STG_W-1:0] stage_p1, tw_shift;
  assign stage_p1 = stage_r + STG_W'(1);
  assign tw_shift = STG_W'(LOG2N - 1) - stage_r;
  assign half     = LOG2N'(1) << stage_r;
  assign kk       = idx_r & (half - LOG2N'(1));
  assign bf_a     = ((idx_r >> stage_r) << stage_p1) | kk;
  assign bf_b     = bf_a | half;
  assign ti_full  = kk << tw_shift;
  assign idx_rev  = bit_rev(idx_r);

  // Read address selection by pass.
  always_comb begin
    ra_addr = idx_r;
    rb_addr = idx_rev;
    case (state_r) inside
      S_BF_RD, S_BF_MUL, S_BF_WA, S_BF_WB: begin
        ra_addr = bf_a;
        rb_addr = bf_b;
      end
      S_GN_RD, S_GN_MUL, S_GN_WA, S_GN_WB: begin
        rb_addr = LOG2N'(0) - idx_r;
      end
      S_OV_RD, S_OV_WR: begin
        rb_addr = {1'b1, idx_r[HA-1:0]};
      end
      default: begin
      end
    endcase
  end
  assign tw_addr = ti_full[HA-1:0];

  // Shared multiplier bank operand selection.
  logic signed [W-1:0]    mx [4];
  logic signed [MY_W-1:0] my [4];
  logic signed [MY_W-1:0] wc, ws, gy;
  assign wc = MY_W'(twc_q_r);
  assign ws = inv_r ? MY_W'(tws_q_r) : -MY_W'(tws_q_r);
  assign gy = MY_W'({2'b00, gain_q_r});

  always_comb begin
    mx[0] = re_b; my[0] = wc;
    mx[1] = im_b; my[1] = ws;
    mx[2] = re_b; my[2] = ws;
    mx[3] = im_b; my[3] = wc;
    if (state_r == S_LD_MUL) begin
      mx[0] = W'($signed(hist_q_r));
      my[0] = MY_W'({3'b000, win_q_r});
    end else if (state_r == S_GN_MUL) begin
      mx[0] = re_a; my[0] = gy;
      mx[1] = im_a; my[1] = gy;
      mx[2] = re_b; my[2] = gy;
      mx[3] = im_b; my[3] = gy;
    end
  end

  // Butterfly sums, with the forward halving.
  logic signed [PROD_W:0] bf_dr, bf_di;
  sum_t bf_tr, bf_ti, bf_ur, bf_ui, bf_vr, bf_vi;
  always_comb begin
    bf_dr = {prod_r[0][PROD_W-1], prod_r[0]} - {prod_r[1][PROD_W-1], prod_r[1]};
    bf_di = {prod_r[2][PROD_W-1], prod_r[2]} + {prod_r[3][PROD_W-1], prod_r[3]};
    bf_tr = SUM_W'(bf_dr >>> 15);
    bf_ti = SUM_W'(bf_di >>> 15);
    bf_ur = SUM_W'(re_a) + bf_tr;
    bf_ui = SUM_W'(im_a) + bf_ti;
    bf_vr = SUM_W'(re_a) - bf_tr;
    bf_vi = SUM_W'(im_a) - bf_ti;
    if (!inv_r) begin
      bf_ur = bf_ur >>> 1;
      bf_ui = bf_ui >>> 1;
      bf_vr = bf_vr >>> 1;
      bf_vi = bf_vi >>> 1;
    end
  end

  // Overlap-add, clamp and scale to 16 bits, truncating toward zero.
  localparam int OS_W = W + 1;
  localparam int PV_W = F + 18;
  logic signed [OS_W-1:0] ov_sum, ov_cl, one_s;
  logic signed [PV_W-1:0] ov_scaled;
  logic                   ov_clip;
  always_comb begin
    one_s   = OS_W'(longint'(1) <<< F);
    ov_sum  = OS_W'(re_a) + OS_W'($signed(ov_q_r));
    ov_cl   = ov_sum;
    ov_clip = 1'b0;
    if (ov_sum > one_s) begin
      ov_cl   = one_s;
      ov_clip = 1'b1;
    end else if (ov_sum < -one_s) begin
      ov_cl   = -one_s;
      ov_clip = 1'b1;
    end
    ov_scaled = (PV_W'(ov_cl) <<< 15) - PV_W'(ov_cl);
    if (ov_scaled < 0) begin
      ov_scaled = ov_scaled + PV_W'((longint'(1) <<< F) - 1);
    end
    ov_scaled = ov_scaled >>> F;
  end

  // Stream counters for an accepted audio or pad request.
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] cnt_off;
  logic [LOG2N-1:0] pad_inc;
  logic             emit;
  assign cnt_inc = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign cnt_off = cnt_r - CNT_W'(N - 1);
  assign pad_inc = pad_r + LOG2N'(1);
  assign emit    = (cnt_r >= CNT_W'(N - 1));

  // Sequencer: next state, counters and memory write controls.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    stage_nxt     = stage_r;
    inv_nxt       = inv_r;
    cnt_nxt       = cnt_r;
    pad_nxt       = pad_r;
    d_nxt         = d_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && !out_tready;
    load_out      = 1'b0;
    hist_we       = 1'b0;
    work_we       = 1'b0;
    work_waddr    = idx_r;
    work_wdata    = '0;
    gain_we       = 1'b0;
    gain_waddr    = idx_r[HA-1:0];
    gain_wdata    = GAIN_W'(GAIN_ONE);
    ov_we         = 1'b0;
    ov_wdata      = '0;
    pend_we       = 1'b0;
    pend_wdata    = {ov_clip, ov_scaled[SAMP_W-1:0]};
    v_load        = 1'b0;
    v_re_nxt      = sat_w(bf_vr);
    v_im_nxt      = sat_w(bf_vi);
    unique case (state_r) inside
      S_INIT: begin
        gain_we = 1'b1;
        ov_we   = 1'b1;
        if (idx_r == LOG2N'(HOP - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + LOG2N'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (kind) inside
            KIND_GAIN: begin
              if (32'(bin_idx) < HOP) begin
                gain_we    = 1'b1;
                gain_waddr = bin_idx[HA-1:0];
                gain_wdata = bin_gain;
              end
            end
            KIND_AUDIO, KIND_PAD: begin
              hist_we   = 1'b1;
              d_nxt     = cnt_off[HA-1:0];
              start_nxt = cnt_inc[LOG2N-1:0];
              cnt_nxt   = (cnt_inc >= (CNT_W + 1)'(2 * N)) ? CNT_W'(N) : cnt_inc[CNT_W-1:0];
              if (kind == KIND_PAD) begin
                if (pad_inc >= LOG2N'(N - 1)) begin
                  cnt_nxt = '0;
                  pad_nxt = '0;
                end else begin
                  pad_nxt = pad_inc;
                end
              end else begin
                pad_nxt = '0;
              end
              if (emit && (cnt_off[HA-1:0] == '0)) begin
                idx_nxt   = '0;
                state_nxt = S_LD_RD;
              end else if (emit) begin
                state_nxt = S_PD_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LD_RD:  state_nxt = S_LD_MUL;
      S_LD_MUL: state_nxt = S_LD_WR;
      S_LD_WR: begin
        work_we    = 1'b1;
        work_waddr = idx_rev;
        work_wdata = {work_t'(0), sat_w(SUM_W'(prod_r[0] >>> (30 - F)))};
        if (idx_r == LOG2N'(N - 1)) begin
          idx_nxt   = '0;
          stage_nxt = '0;
          inv_nxt   = 1'b0;
          state_nxt = S_BF_RD;
        end else begin
          idx_nxt   = idx_r + LOG2N'(1);
          state_nxt = S_LD_RD;
        end
      end
      S_BF_RD:  state_nxt = S_BF_MUL;
      S_BF_MUL: state_nxt = S_BF_WA;
      S_BF_WA: begin
        work_we    = 1'b1;
        work_waddr = bf_a;
        work_wdata = {sat_w(bf_ui), sat_w(bf_ur)};
        v_load     = 1'b1;
        state_nxt  = S_BF_WB;
      end
      S_BF_WB: begin
        work_we    = 1'b1;
        work_waddr = bf_b;
        work_wdata = {v_im_r, v_re_r};
        state_nxt  = S_BF_RD;
        if (idx_r == LOG2N'(HOP - 1)) begin
          idx_nxt = '0;
          if (stage_r == STG_W'(LOG2N - 1)) begin
            stage_nxt = '0;
            state_nxt = inv_r ? S_OV_RD : S_GN_RD;
          end else begin
            stage_nxt = stage_p1;
          end
        end else begin
          idx_nxt = idx_r + LOG2N'(1);
        end
      end
      S_GN_RD:  state_nxt = S_GN_MUL;
      S_GN_MUL: state_nxt = S_GN_WA;
      S_GN_WA: begin
        work_we    = 1'b1;
        work_wdata = {sat_w(SUM_W'(prod_r[1] >>> 12)), sat_w(SUM_W'(prod_r[0] >>> 12))};
        v_re_nxt   = sat_w(SUM_W'(prod_r[2] >>> 12));
        v_im_nxt   = sat_w(SUM_W'(prod_r[3] >>> 12));
        v_load     = 1'b1;
        state_nxt  = S_GN_WB;
      end
      S_GN_WB: begin
        // The mirror of bin zero is bin zero itself.
        work_we    = (idx_r != '0);
        work_waddr = rb_addr;
        work_wdata = {v_im_r, v_re_r};
        if (idx_r == LOG2N'(HOP - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_SW_RD;
        end else begin
          idx_nxt   = idx_r + LOG2N'(1);
          state_nxt = S_GN_RD;
        end
      end
      S_SW_RD, S_SW_WR: begin
        if ((state_r == S_SW_RD) && (idx_rev > idx_r)) begin
          state_nxt = S_SW_WJ;
        end else begin
          if (state_r == S_SW_WR) begin
            work_we    = 1'b1;
            work_waddr = idx_rev;
            work_wdata = rd_a_r;
          end
          state_nxt = S_SW_RD;
          if (idx_r == LOG2N'(N - 1)) begin
            idx_nxt   = '0;
            stage_nxt = '0;
            inv_nxt   = 1'b1;
            state_nxt = S_BF_RD;
          end else begin
            idx_nxt = idx_r + LOG2N'(1);
          end
        end
      end
      S_SW_WJ: begin
        work_we    = 1'b1;
        work_wdata = rd_b_r;
        state_nxt  = S_SW_WR;
      end
      S_OV_RD: state_nxt = S_OV_WR;
      S_OV_WR: begin
        pend_we  = 1'b1;
        ov_we    = 1'b1;
        ov_wdata = re_b;
        if (idx_r == LOG2N'(HOP - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_PD_RD;
        end else begin
          idx_nxt   = idx_r + LOG2N'(1);
          state_nxt = S_OV_RD;
        end
      end
      S_PD_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      stage_r     <= '0;
      inv_r       <= 1'b0;
      cnt_r       <= '0;
      pad_r       <= '0;
      d_r         <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      stage_r     <= stage_nxt;
      inv_r       <= inv_nxt;
      cnt_r       <= cnt_nxt;
      pad_r       <= pad_nxt;
      d_r         <= d_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[cnt_r[LOG2N-1:0]] <= (kind == KIND_PAD) ? '0 : smp_in;
    end
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (gain_we) begin
      gain_mem[gain_waddr] <= gain_wdata;
    end
    if (ov_we) begin
      ov_mem[idx_r[HA-1:0]] <= ov_wdata;
    end
    if (pend_we) begin
      pend_mem[idx_r[HA-1:0]] <= pend_wdata;
    end
  end

  // Registered reads, multiplier bank and output register.
  always_ff @(posedge clk) begin
    hist_q_r <= hist_mem[start_r + idx_r];
    win_q_r  <= WIN_ROM[idx_r];
    twc_q_r  <= TW_COS[tw_addr];
    tws_q_r  <= TW_SIN[tw_addr];
    rd_a_r   <= work_mem[ra_addr];
    rd_b_r   <= work_mem[rb_addr];
    gain_q_r <= gain_mem[idx_r[HA-1:0]];
    ov_q_r   <= ov_mem[idx_r[HA-1:0]];
    pend_q_r <= pend_mem[d_r];
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= PROD_W'(mx[i]) * PROD_W'(my[i]);
    end
    if (v_load) begin
      v_re_r <= v_re_nxt;
      v_im_r <= v_im_nxt;
    end
    if (load_out) begin
      out_data_r <= pend_q_r[SAMP_W-1:0];
      out_clip_r <= pend_q_r[SAMP_W];
    end
  end

endmodule

// File: dv/fft_overlap_add_equalizer_unit_test.sv
`timescale 1ns / 100ps

module fft_overlap_add_equalizer_unit_test import eqola_pkg::*; ();

  // Kind code that the block ignores.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [15:0]       smp;
    logic [8:0]        idx;
    logic [15:0]       gain;
    bit                drain;
  } request_t;

  typedef struct {
    logic [15:0] smp;
    logic        clip;
  } eq_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [SAMP_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  fft_overlap_add_equalizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t   pending_reqs[$];
  eq_sample_t expected_samples[$];

  // Predictor state.
  longint win_q15[N];
  longint twc[HOP];
  longint tws[HOP];
  longint hist[N];
  longint wre[N];
  longint wim[N];
  longint gains[HOP];
  longint tail[HOP];
  longint pend_v[HOP];
  bit     pend_c[HOP];
  int unsigned sample_pos;
  int unsigned pads_seen;

  int mismatches = 0;
  int results_seen = 0;
  int clips_seen = 0;
  int audio_sent = 0;
  int pads_sent = 0;
  int gains_sent = 0;
  bit in_taken = 1'b0;

  function automatic longint clamp_work(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (W - 1)) - 1;
    lo = -(longint'(1) <<< (W - 1));
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Quarter-wave sine polynomial, Q30 in and out.
  function automatic longint quarter_sine(input longint x);
    longint x2, t, r;
    x2 = (x * x) >>> 30;
    t = 64'd5026995 - ((x2 * 64'd172272) >>> 30);
    t = 64'd85569306 - ((x2 * t) >>> 30);
    t = 64'd693598668 - ((x2 * t) >>> 30);
    t = 64'd1686629713 - ((x2 * t) >>> 30);
    r = (x * t) >>> 30;
    return (r > 64'd1073741824) ? 64'd1073741824 : r;
  endfunction

  // Cosine and sine of a phase where 2^32 is one turn.
  task automatic phase_trig(input longint ph, output longint c, output longint s);
    longint q, r, a, b;
    q = (ph >> 30) & 3;
    r = ph & 64'h3FFFFFFF;
    a = quarter_sine(r);
    b = quarter_sine(64'd1073741824 - r);
    case (q)
      0: begin c = b; s = a; end
      1: begin c = -a; s = b; end
      2: begin c = -b; s = -a; end
      default: begin c = a; s = -b; end
    endcase
  endtask

  // In-place radix-2 transform; the forward one halves at every stage.
  task automatic transform(input bit inverse);
    int r, half, step, ti, a, b;
    longint t, wc, ws, tr, tim, ur, ui, vr, vi;
    for (int j = 0; j < N; j++) begin
      r = 0;
      for (int k = 0; k < LOG2N; k++) r = (r << 1) | ((j >> k) & 1);
      if (r > j) begin
        t = wre[j]; wre[j] = wre[r]; wre[r] = t;
        t = wim[j]; wim[j] = wim[r]; wim[r] = t;
      end
    end
    for (int len = 2; len <= N; len = len * 2) begin
      half = len / 2;
      step = N / len;
      for (int base = 0; base < N; base += len) begin
        for (int k = 0; k < half; k++) begin
          a = base + k;
          b = a + half;
          ti = (k * step) & (HOP - 1);
          wc = twc[ti];
          ws = inverse ? tws[ti] : -tws[ti];
          tr = (wre[b] * wc - wim[b] * ws) >>> 15;
          tim = (wre[b] * ws + wim[b] * wc) >>> 15;
          ur = wre[a] + tr; ui = wim[a] + tim;
          vr = wre[a] - tr; vi = wim[a] - tim;
          if (!inverse) begin
            ur = ur >>> 1; ui = ui >>> 1; vr = vr >>> 1; vi = vi >>> 1;
          end
          wre[a] = clamp_work(ur); wim[a] = clamp_work(ui);
          wre[b] = clamp_work(vr); wim[b] = clamp_work(vi);
        end
      end
    end
  endtask

  // One frame: window, forward FFT, per-bin gain, inverse FFT, overlap-add.
  task automatic equalize_frame(input int unsigned start);
    longint one, s, g;
    int m;
    one = longint'(1) <<< F;
    for (int j = 0; j < N; j++) begin
      wre[j] = clamp_work((hist[(start + j) % N] * win_q15[j]) >>> (30 - F));
      wim[j] = 0;
    end
    transform(1'b0);
    for (int j = 0; j < HOP; j++) begin
      g = gains[j];
      wre[j] = clamp_work((wre[j] * g) >>> 12);
      wim[j] = clamp_work((wim[j] * g) >>> 12);
      if (j > 0) begin
        m = N - j;
        wre[m] = clamp_work((wre[m] * g) >>> 12);
        wim[m] = clamp_work((wim[m] * g) >>> 12);
      end
    end
    transform(1'b1);
    for (int j = 0; j < HOP; j++) begin
      s = wre[j] + tail[j];
      pend_c[j] = 1'b0;
      if (s > one) begin
        s = one; pend_c[j] = 1'b1;
      end else if (s < -one) begin
        s = -one; pend_c[j] = 1'b1;
      end
      pend_v[j] = (s * 32767) / one;
      tail[j] = wre[j + HOP];
    end
  endtask

  // Update the predicted state for one accepted request.
  task automatic predict_request(input request_t rq);
    longint smp;
    int unsigned d;
    eq_sample_t e;
    if (rq.kind == KIND_GAIN) begin
      if (rq.idx < HOP) gains[rq.idx] = rq.gain;
      return;
    end
    if (rq.kind != KIND_AUDIO && rq.kind != KIND_PAD) return;
    smp = (rq.kind == KIND_PAD) ? 0 : longint'($signed(rq.smp));
    hist[sample_pos % N] = smp;
    if (sample_pos >= N - 1) begin
      d = (sample_pos - (N - 1)) % HOP;
      if (d == 0) equalize_frame((sample_pos + 1) % N);
      e.smp = pend_v[d][15:0];
      e.clip = pend_c[d];
      expected_samples = {expected_samples, e};
    end
    sample_pos++;
    if (sample_pos >= 2 * N) sample_pos = N;
    if (rq.kind == KIND_PAD) begin
      pads_seen++;
      if (pads_seen >= N - 1) begin
        sample_pos = 0;
        pads_seen = 0;
      end
    end else begin
      pads_seen = 0;
    end
  endtask

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [15:0] smp,
                               input logic [8:0] idx, input logic [15:0] gain,
                               input bit drain);
    request_t rq;
    rq.kind = kind; rq.smp = smp; rq.idx = idx; rq.gain = gain; rq.drain = drain;
    pending_reqs = {pending_reqs, rq};
  endtask

  // Random audio, sometimes at full scale, with an occasional gain write mixed in.
  task automatic queue_stream(input int count);
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        queue_request(KIND_GAIN, 16'($urandom), 9'($urandom), 16'($urandom), 1'b0);
      end
      case ($urandom_range(0, 9)) inside
        0: s = 16'h8000;
        1: s = 16'h7FFF;
        2, 3: s = 16'($signed(16'($urandom_range(0, 512))) - 256);
        default: s = 16'($urandom);
      endcase
      queue_request(KIND_AUDIO, s, 9'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  task automatic queue_pads(input int count);
    for (int i = 0; i < count; i++) begin
      queue_request(KIND_PAD, 16'($urandom), 9'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    longint c, s, ph;
    for (int j = 0; j < N; j++) begin
      ph = ((longint'(j) << 32) / (N - 1)) & 64'hFFFFFFFF;
      phase_trig(ph, c, s);
      c = ((64'd1073741824 - c) + 32768) >>> 16;
      win_q15[j] = (c > 32767) ? 32767 : c;
      hist[j] = 0;
    end
    for (int j = 0; j < HOP; j++) begin
      ph = ((longint'(j) << 32) / N) & 64'hFFFFFFFF;
      phase_trig(ph, c, s);
      twc[j] = (c + 16384) >>> 15;
      tws[j] = (s + 16384) >>> 15;
      gains[j] = GAIN_ONE;
      tail[j] = 0;
      pend_v[j] = 0;
      pend_c[j] = 1'b0;
    end
    sample_pos = 0;
    pads_seen = 0;

    // Directed part: gain extremes, an unused kind, full-scale and zero samples.
    queue_request(KIND_GAIN, 16'h0000, 9'd0, 16'h0000, 1'b0);
    queue_request(KIND_GAIN, 16'hFFFF, 9'd511, 16'hFFFF, 1'b0);
    queue_request(KIND_GAIN, 16'h0000, 9'd3, 16'hFFFF, 1'b0);
    queue_request(KIND_GAIN, 16'h0000, 9'd256, 16'h0001, 1'b0);
    queue_request(KIND_SPARE, 16'hFFFF, 9'h1FF, 16'hFFFF, 1'b0);
    queue_request(KIND_AUDIO, 16'h8000, 9'h1FF, 16'hFFFF, 1'b0);
    queue_request(KIND_AUDIO, 16'h7FFF, 9'd0, 16'h0000, 1'b0);
    queue_request(KIND_AUDIO, 16'h0000, 9'd0, 16'h0000, 1'b0);
    queue_request(KIND_AUDIO, 16'hFFFF, 9'd0, 16'h0000, 1'b0);
    queue_request(KIND_SPARE, 16'h1234, 9'd7, 16'h0042, 1'b0);

    // First stream; a stray audio sample among the pads restarts the pad count.
    queue_stream(60);
    queue_pads(10);
    queue_request(KIND_AUDIO, 16'h4000, 9'd0, 16'h0000, 1'b0);
    queue_pads(N - 1);

    // Wait for the output to drain, retune a few bins, then start a second stream
    // that must stay silent until it has enough samples.
    queue_request(KIND_GAIN, 16'h0000, 9'd0, 16'd4096, 1'b1);
    queue_request(KIND_GAIN, 16'h0000, 9'd10, 16'd16384, 1'b0);
    queue_stream(20);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_samples.size() == 0);
    repeat (200) @(posedge clk);
    if (expected_samples.size() != 0) mismatches++;

    $display("Sent %0d audio samples, %0d pads and %0d gain writes over two streams.",
             audio_sent, pads_sent, gains_sent);
    $display("Checked %0d equalized samples, %0d of them clipped; %0d mismatches.",
             results_seen, clips_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

  // Input side: record each accepted request and predict its result.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      case (pending_reqs[0].kind)
        KIND_AUDIO: audio_sent++;
        KIND_PAD: pads_sent++;
        KIND_GAIN: gains_sent++;
        default: ;
      endcase
      predict_request(pending_reqs.pop_front());
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_reqs[0].drain && expected_samples.size() != 0) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_reqs[0].kind;
        in_tdata <= {7'd0, pending_reqs[0].gain, pending_reqs[0].idx, pending_reqs[0].smp};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // One long receiver hold once some results have come out, counted in cycles.
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!long_hold_done && results_seen >= 30) begin
      long_hold_done = 1'b1;
      hold_left = 3000;
    end
  end

  // Receiver: random stalls in some stretches, none in others.
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 200);
      stall_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
    end else if (stall_mode == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result side: compare each accepted sample against the oldest prediction.
  always @(posedge clk) begin
    eq_sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[0]) clips_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected sample %h clip %b", out_tdata, out_tuser);
      end else begin
        e = expected_samples.pop_front();
        if (out_tdata !== e.smp || out_tuser[0] !== e.clip) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Sample %0d: expected %h clip %b, got %h clip %b",
                     results_seen, e.smp, e.clip, out_tdata, out_tuser);
          end
        end
      end
    end
  end

endmodule
